/* rtl/core/cpt_pkg.sv */
// Shared types and constants for the compression pause timer.
package cpt_pkg;

    localparam int SEG_W     = 24;
    localparam int ELAPSED_W = 16;
    localparam int PCT_W     = 7;
    localparam int CFG_W     = 24;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SEG_W-1:0] SEG_MAX = '1;

    localparam logic [CFG_W-1:0] SWAP_NOW_RST     = 24'd120000;
    localparam logic [CFG_W-1:0] SWAP_WARN_RST    = 24'd115000;
    localparam logic [CFG_W-1:0] SWAP_PREPARE_RST = 24'd90000;
    localparam logic [CFG_W-1:0] STALL_ALERT_RST  = 24'd5000;
    localparam logic [LEN_W-1:0] STALL_LEN_RST    = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWAP_NOW     = 3'd0,
        CFG_SWAP_WARN    = 3'd1,
        CFG_SWAP_PREPARE = 3'd2,
        CFG_STALL_ALERT  = 3'd3,
        CFG_STALL_LEN    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_PRESS = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ADV_NONE         = 3'd0,
        ADV_PREPARE_SWAP = 3'd1,
        ADV_SWAP_WARN    = 3'd2,
        ADV_SWAP_NOW     = 3'd3,
        ADV_STALL_ALERT  = 3'd4
    } advice_t;

    typedef struct packed {
        op_t                  op;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic             session_started;
        logic             compressing;
        logic [SEG_W-1:0] segment_ms;
        advice_t          advice;
        logic [PCT_W-1:0] fraction_pct;
        logic             fraction_valid;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] swap_now_ms;
        logic [CFG_W-1:0] swap_warn_ms;
        logic [CFG_W-1:0] swap_prepare_ms;
        logic [CFG_W-1:0] stall_alert_ms;
        logic [LEN_W-1:0] stall_alert_len_ms;
    } cfg_t;

endpackage

/* rtl/core/compression_pause_timer_unit.sv */
// Compression and pause timer: front end, entry queue and back end.
// An accepted item is queued, then the back end loads it, sets up the division, runs the divider and holds its result.
// The back end takes a new item only after its 7-step percentage divider is done and the result is taken.
// The front end keeps taking items while the two-entry queue has room.
// Reset (rst_n, asynchronous, active low) clears session state, totals and the queue
// and loads the default thresholds; no clearing pass is needed.
module compression_pause_timer_unit #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  cpt_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output cpt_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]     cfg_data
);

    localparam int ENTRY_W = 3 + cpt_pkg::SEG_W + 2 * TOTAL_BITS;

    cpt_pkg::cfg_t        cfg;
    logic                 q_push;
    logic                 q_ready;
    logic [ENTRY_W-1:0]   q_in;
    logic                 q_valid;
    logic                 q_pop;
    logic [ENTRY_W-1:0]   q_out;

    cpt_front #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .q_push     (q_push),
        .q_ready    (q_ready),
        .q_data     (q_in)
    );

    cpt_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (cpt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    cpt_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_out),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/core/cpt_front.sv */
// Front end: configuration registers, session state and totals, one queue entry per item.
module cpt_front #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       item_valid,
    output logic                                       item_stall,
    input  cpt_pkg::item_t                             item,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]                  cfg_data,
    output cpt_pkg::cfg_t                              cfg,
    output logic                                       q_push,
    input  logic                                       q_ready,
    output logic [3+cpt_pkg::SEG_W+2*TOTAL_BITS-1:0]   q_data
);

    typedef struct packed {
        logic                       tick_started;
        logic                       started;
        logic                       compressing;
        logic [cpt_pkg::SEG_W-1:0]  seg;
        logic [TOTAL_BITS-1:0]      total_c;
        logic [TOTAL_BITS-1:0]      total_p;
    } entry_t;

    cpt_pkg::cfg_t cfg_reg;

    logic                      started_reg, started_next;
    logic                      compress_reg, compress_next;
    logic                      last_seen_reg, last_seen_next;
    logic [cpt_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic [TOTAL_BITS-1:0]     total_c_reg, total_c_next;
    logic [TOTAL_BITS-1:0]     total_p_reg, total_p_next;

    logic                      accept;
    logic [cpt_pkg::SEG_W:0]   seg_sum;
    logic [TOTAL_BITS:0]       tot_sum;
    logic [TOTAL_BITS-1:0]     tot_add;
    entry_t                    ent;

    assign cfg_ready  = 1'b1;
    assign cfg        = cfg_reg;
    assign item_stall = !q_ready;
    assign accept     = item_valid && !item_stall;

    assign seg_sum = {1'b0, seg_reg} + (cpt_pkg::SEG_W+1)'(item.elapsed_ms);
    assign tot_add = compress_reg ? total_c_reg : total_p_reg;
    assign tot_sum = {1'b0, tot_add} + (TOTAL_BITS+1)'(item.elapsed_ms);

    always_comb
    begin
        started_next   = started_reg;
        compress_next  = compress_reg;
        last_seen_next = last_seen_reg;
        seg_next       = seg_reg;
        total_c_next   = total_c_reg;
        total_p_next   = total_p_reg;
        if (accept)
        begin
            if (item.op == cpt_pkg::OP_PRESS)
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    seg_next     = '0;
                    total_c_next = '0;
                    total_p_next = '0;
                end
                else
                begin
                    compress_next = !compress_reg;
                end
            end
            else if (started_reg)
            begin
                // The first tick after a net change of state restarts the segment.
                if (compress_reg != last_seen_reg)
                begin
                    last_seen_next = compress_reg;
                    seg_next       = '0;
                end
                else
                begin
                    seg_next = seg_sum[cpt_pkg::SEG_W] ? cpt_pkg::SEG_MAX
                                                       : seg_sum[cpt_pkg::SEG_W-1:0];
                end
                if (compress_reg)
                    total_c_next = tot_sum[TOTAL_BITS] ? '1 : tot_sum[TOTAL_BITS-1:0];
                else
                    total_p_next = tot_sum[TOTAL_BITS] ? '1 : tot_sum[TOTAL_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        ent.tick_started = (item.op == cpt_pkg::OP_TICK) && started_reg;
        ent.started      = started_next;
        ent.compressing  = compress_next;
        ent.seg          = seg_next;
        ent.total_c      = total_c_next;
        ent.total_p      = total_p_next;
    end

    assign q_push = accept;
    assign q_data = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            compress_reg  <= 1'b0;
            last_seen_reg <= 1'b0;
            seg_reg       <= '0;
            total_c_reg   <= '0;
            total_p_reg   <= '0;
        end
        else
        begin
            started_reg   <= started_next;
            compress_reg  <= compress_next;
            last_seen_reg <= last_seen_next;
            seg_reg       <= seg_next;
            total_c_reg   <= total_c_next;
            total_p_reg   <= total_p_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_now_ms        <= cpt_pkg::SWAP_NOW_RST;
            cfg_reg.swap_warn_ms       <= cpt_pkg::SWAP_WARN_RST;
            cfg_reg.swap_prepare_ms    <= cpt_pkg::SWAP_PREPARE_RST;
            cfg_reg.stall_alert_ms     <= cpt_pkg::STALL_ALERT_RST;
            cfg_reg.stall_alert_len_ms <= cpt_pkg::STALL_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cpt_pkg::CFG_SWAP_NOW:     cfg_reg.swap_now_ms     <= cfg_data;
                cpt_pkg::CFG_SWAP_WARN:    cfg_reg.swap_warn_ms    <= cfg_data;
                cpt_pkg::CFG_SWAP_PREPARE: cfg_reg.swap_prepare_ms <= cfg_data;
                cpt_pkg::CFG_STALL_ALERT:  cfg_reg.stall_alert_ms  <= cfg_data;
                cpt_pkg::CFG_STALL_LEN:
                    cfg_reg.stall_alert_len_ms <= cfg_data[cpt_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/cpt_queue.sv */
// Small register queue between the front end and the back end.
module cpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/cpt_back.sv */
// Back end: advice code, compression percentage by a restoring divider, result register.
module cpt_back #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  cpt_pkg::cfg_t                              cfg,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [3+cpt_pkg::SEG_W+2*TOTAL_BITS-1:0]   q_data,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output cpt_pkg::result_t                           result
);

    localparam int NUM_W  = TOTAL_BITS + cpt_pkg::PCT_W;
    localparam int STEP_W = $clog2(cpt_pkg::PCT_W);

    typedef struct packed {
        logic                       tick_started;
        logic                       started;
        logic                       compressing;
        logic [cpt_pkg::SEG_W-1:0]  seg;
        logic [TOTAL_BITS-1:0]      total_c;
        logic [TOTAL_BITS-1:0]      total_p;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                    state_reg;
    entry_t                    ent_reg;
    cpt_pkg::advice_t          advice_reg;
    logic                      fvalid_reg;
    logic [NUM_W-1:0]          rem_reg;
    logic [NUM_W-1:0]          dsh_reg;
    logic [cpt_pkg::PCT_W-1:0] quo_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      valid_reg;

    cpt_pkg::advice_t          advice;
    logic [cpt_pkg::CFG_W:0]   stall_end;
    logic [NUM_W-1:0]          numer;
    logic [TOTAL_BITS:0]       denom;
    logic                      fits;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    assign stall_end = {1'b0, cfg.stall_alert_ms} + (cpt_pkg::CFG_W+1)'(cfg.stall_alert_len_ms);

    always_comb
    begin
        advice = cpt_pkg::ADV_NONE;
        if (ent_reg.tick_started)
        begin
            if (ent_reg.compressing)
            begin
                priority if (ent_reg.seg >= cfg.swap_now_ms)
                    advice = cpt_pkg::ADV_SWAP_NOW;
                else if (ent_reg.seg >= cfg.swap_warn_ms)
                    advice = cpt_pkg::ADV_SWAP_WARN;
                else if (ent_reg.seg > cfg.swap_prepare_ms)
                    advice = cpt_pkg::ADV_PREPARE_SWAP;
                else
                    advice = cpt_pkg::ADV_NONE;
            end
            else if (ent_reg.seg >= cfg.stall_alert_ms && {1'b0, ent_reg.seg} < stall_end)
            begin
                advice = cpt_pkg::ADV_STALL_ALERT;
            end
        end
    end

    // 100 * compress time, built from shifts.
    assign numer = (NUM_W'(ent_reg.total_c) << 6) + (NUM_W'(ent_reg.total_c) << 5)
                 + (NUM_W'(ent_reg.total_c) << 2);
    assign denom = {1'b0, ent_reg.total_c} + {1'b0, ent_reg.total_p};
    assign fits  = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ent_reg    <= '0;
            advice_reg <= cpt_pkg::ADV_NONE;
            fvalid_reg <= 1'b0;
            rem_reg    <= '0;
            dsh_reg    <= '0;
            quo_reg    <= '0;
            step_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        ent_reg   <= q_data;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    advice_reg <= advice;
                    fvalid_reg <= ent_reg.total_p != '0;
                    rem_reg    <= numer;
                    // The quotient never exceeds 100, so seven steps from 64 * sum suffice.
                    dsh_reg    <= NUM_W'(denom) << (cpt_pkg::PCT_W - 1);
                    quo_reg    <= '0;
                    step_reg   <= '0;
                    state_reg  <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (fits)
                        rem_reg <= rem_reg - dsh_reg;
                    quo_reg  <= {quo_reg[cpt_pkg::PCT_W-2:0], fits};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(cpt_pkg::PCT_W - 1))
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (!result_stall)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = valid_reg;

    always_comb
    begin
        result.session_started = ent_reg.started;
        result.compressing     = ent_reg.compressing;
        result.segment_ms      = ent_reg.seg;
        result.advice          = advice_reg;
        result.fraction_pct    = fvalid_reg ? quo_reg : '0;
        result.fraction_valid  = fvalid_reg;
    end

endmodule

/* rtl/core/cpt_checker.sv */
// Port-level checks for the compression pause timer, bound to the top level.
module cpt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input cpt_pkg::result_t result
);

    // A stalled result transfer keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.fraction_pct <= 7'd100)
        else $error("fraction above 100 percent");

    a_pct_gated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fraction_valid |-> result.fraction_pct == '0)
        else $error("fraction reported without pause time");

    // Before the session starts nothing moves.
    a_idle_session: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.session_started |->
            !result.compressing && result.segment_ms == '0 &&
            result.advice == cpt_pkg::ADV_NONE && !result.fraction_valid)
        else $error("activity before session start");

endmodule

bind compression_pause_timer_unit cpt_checker u_cpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* sim/pause_timer_checker.sv */
// Watches the timer's channels, predicts each reading and compares it with the block's output.
`timescale 1ns / 1ps

module pause_timer_checker #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  cpt_pkg::item_t                item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  cpt_pkg::result_t              result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]     cfg_data,
    output int                            error_count,
    output int                            outstanding
);
    import cpt_pkg::*;

    logic                  started;
    logic                  compressing;
    logic                  seen_compressing;
    logic [SEG_W-1:0]      segment;
    logic [TOTAL_BITS-1:0] compress_total;
    logic [TOTAL_BITS-1:0] pause_total;

    logic [CFG_W-1:0] swap_now;
    logic [CFG_W-1:0] swap_warn;
    logic [CFG_W-1:0] swap_prepare;
    logic [CFG_W-1:0] stall_start;
    logic [LEN_W-1:0] stall_len;

    result_t expected_readings[$];
    result_t oldest;

    function automatic logic [TOTAL_BITS-1:0] add_saturated(logic [TOTAL_BITS-1:0] total,
                                                            logic [ELAPSED_W-1:0] ms);
        logic [TOTAL_BITS:0] sum;
        sum = {1'b0, total} + ms;
        return sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    endfunction

    function automatic advice_t advice_for_segment();
        if (compressing)
        begin
            if (segment >= swap_now)
                return ADV_SWAP_NOW;
            if (segment >= swap_warn)
                return ADV_SWAP_WARN;
            if (segment > swap_prepare)
                return ADV_PREPARE_SWAP;
            return ADV_NONE;
        end
        // The window end is taken one bit wider so that it cannot wrap.
        if (segment >= stall_start && {1'b0, segment} < {1'b0, stall_start} + stall_len)
            return ADV_STALL_ALERT;
        return ADV_NONE;
    endfunction

    // Advances the timer state by one item and returns the reading it should produce.
    function automatic result_t predict_timer_reading(item_t it);
        result_t               reading;
        logic [SEG_W:0]        seg_sum;
        logic [TOTAL_BITS+7:0] scaled;
        logic [TOTAL_BITS+7:0] whole;
        logic [TOTAL_BITS+7:0] quotient;
        reading.advice = ADV_NONE;
        if (it.op == OP_PRESS)
        begin
            if (!started)
            begin
                started = 1'b1;
                compress_total = '0;
                pause_total = '0;
                segment = '0;
            end
            else
                compressing = !compressing;
        end
        else if (started)
        begin
            // The segment restarts on the first tick after a net change of state.
            if (compressing != seen_compressing)
            begin
                seen_compressing = compressing;
                segment = '0;
            end
            else
            begin
                seg_sum = {1'b0, segment} + it.elapsed_ms;
                segment = seg_sum[SEG_W] ? SEG_MAX : seg_sum[SEG_W-1:0];
            end
            if (compressing)
                compress_total = add_saturated(compress_total, it.elapsed_ms);
            else
                pause_total = add_saturated(pause_total, it.elapsed_ms);
            reading.advice = advice_for_segment();
        end
        reading.fraction_pct = '0;
        reading.fraction_valid = 1'b0;
        if (pause_total != '0)
        begin
            whole = {8'd0, compress_total} + {8'd0, pause_total};
            scaled = {8'd0, compress_total} * 8'd100;
            quotient = scaled / whole;
            reading.fraction_pct = quotient[PCT_W-1:0];
            reading.fraction_valid = 1'b1;
        end
        reading.session_started = started;
        reading.compressing = compressing;
        reading.segment_ms = segment;
        return reading;
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started <= 1'b0;
            compressing <= 1'b0;
            seen_compressing <= 1'b0;
            segment <= '0;
            compress_total <= '0;
            pause_total <= '0;
            swap_now <= SWAP_NOW_RST;
            swap_warn <= SWAP_WARN_RST;
            swap_prepare <= SWAP_PREPARE_RST;
            stall_start <= STALL_ALERT_RST;
            stall_len <= STALL_LEN_RST;
            expected_readings.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SWAP_NOW:     swap_now = cfg_data;
                    CFG_SWAP_WARN:    swap_warn = cfg_data;
                    CFG_SWAP_PREPARE: swap_prepare = cfg_data;
                    CFG_STALL_ALERT:  stall_start = cfg_data;
                    CFG_STALL_LEN:    stall_len = cfg_data[LEN_W-1:0];
                    default:          ;
                endcase
            end
            // Retire first, so that a stray reading cannot match an item taken at this edge.
            if (result_valid && !result_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: reading %h arrived with none expected", $time, result);
                    error_count++;
                end
                else
                begin
                    oldest = expected_readings.pop_front();
                    check_field("session_started", oldest.session_started,
                                result.session_started);
                    check_field("compressing", oldest.compressing, result.compressing);
                    check_field("segment_ms", oldest.segment_ms, result.segment_ms);
                    check_field("advice", oldest.advice, result.advice);
                    check_field("fraction_pct", oldest.fraction_pct, result.fraction_pct);
                    check_field("fraction_valid", oldest.fraction_valid,
                                result.fraction_valid);
                end
            end
            if (item_valid && !item_stall)
                expected_readings.push_back(predict_timer_reading(item));
            outstanding <= expected_readings.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Stimulus, flow control and verdict for the compression pause timer.
`timescale 1ns / 1ps

module testbench;
    import cpt_pkg::*;

    localparam int LATENCY_WAIT   = 12;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum {SPAN_SHORT, SPAN_MID, SPAN_FULL} elapsed_span_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    item_t            item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    int error_count;
    int outstanding;
    int presses_sent = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int stall_left = 0;
    int result_gap;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;

    compression_pause_timer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pause_timer_checker timer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Reading side: a random wait after each transfer, plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            result_stall <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end
        else if (result_valid && !result_stall)
        begin
            result_gap = no_gaps ? 0 : $urandom_range(0, 6);
            result_stall <= (result_gap != 0);
            stall_left <= (result_gap != 0) ? result_gap - 1 : 0;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("testbench: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_reading(item_t next);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= next;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        if (next.op == OP_PRESS)
            presses_sent++;
    endtask

    task automatic send_tick(logic [ELAPSED_W-1:0] ms);
        item_t next;
        next.op = OP_TICK;
        next.elapsed_ms = ms;
        send_reading(next);
    endtask

    task automatic send_press();
        item_t next;
        next.op = OP_PRESS;
        next.elapsed_ms = $urandom_range(0, 65535);
        send_reading(next);
    endtask

    // Waits until every expected reading is back and the block has gone quiet.
    task automatic settle_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] now_ms, logic [CFG_W-1:0] warn_ms,
                                  logic [CFG_W-1:0] prepare_ms, logic [CFG_W-1:0] stall_ms,
                                  logic [LEN_W-1:0] len_ms);
        settle_results();
        write_register(CFG_SWAP_NOW, now_ms);
        write_register(CFG_SWAP_WARN, warn_ms);
        write_register(CFG_SWAP_PREPARE, prepare_ms);
        write_register(CFG_STALL_ALERT, stall_ms);
        write_register(CFG_STALL_LEN, {{(CFG_W-LEN_W){1'b0}}, len_ms});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_items(int count, elapsed_span_t span);
        item_t next;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                no_gaps <= 1'b0;
            else if (n % 150 == 120)
                no_gaps <= 1'b1;
            next.op = ($urandom_range(0, 11) == 0) ? OP_PRESS : OP_TICK;
            case (span)
                SPAN_SHORT: next.elapsed_ms = $urandom_range(0, 400);
                SPAN_MID:   next.elapsed_ms = $urandom_range(0, 20000);
                default:    next.elapsed_ms = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 15) == 0)
                next.elapsed_ms = $urandom_range(0, 65535);
            else if ($urandom_range(0, 31) == 0)
                next.elapsed_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            send_reading(next);
        end
        no_gaps <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: ticks before the session, then walk through every advice level.
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_press();
        send_tick(16'd100);
        send_tick(16'd4900);
        send_tick(16'd999);
        send_tick(16'd1);
        send_press();
        send_tick(16'd500);
        send_tick(16'hFFFF);
        send_tick(16'd24465);
        send_tick(16'd1);
        send_tick(16'd24998);
        send_tick(16'd1);
        send_tick(16'd4999);
        send_tick(16'd1);
        // Two presses before a tick cancel out, so the segment keeps running.
        send_press();
        send_press();
        send_tick(16'h0000);
        send_tick(16'hFFFF);

        apply_settings(24'd3000, 24'd2000, 24'd1000, 24'd500, 16'd300);
        run_random_items(150, SPAN_SHORT);
        // Hold the output long enough for the block to fill and push back.
        holds_asked <= holds_asked + 1;
        run_random_items(250, SPAN_SHORT);

        apply_settings(24'd0, 24'd0, 24'd0, 24'd0, 16'd1);
        run_random_items(200, SPAN_FULL);

        apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        run_random_items(200, SPAN_FULL);

        apply_settings(24'd1000, 24'd5000, 24'd20000, 24'hFFFF00, 16'hFFFF);
        // An odd number of presses so far means paused.
        if (presses_sent % 2 == 0)
            send_press();
        no_gaps <= 1'b1;
        repeat (260) send_tick(16'hFFFF);
        send_press();
        // A short run of full ticks while compressing.
        repeat (20) send_tick(16'hFFFF);
        no_gaps <= 1'b0;
        run_random_items(200, SPAN_FULL);

        apply_settings(SWAP_NOW_RST, SWAP_WARN_RST, SWAP_PREPARE_RST, STALL_ALERT_RST,
                       STALL_LEN_RST);
        run_random_items(250, SPAN_MID);
        settle_results();
        run_random_items(30, SPAN_MID);

        settle_results();
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
